// ===== sv/dll_pkg.sv =====
// shared types and constants of the doubly linked list manager
// request and result structs, opcodes, default pool size; no dependencies
`default_nettype none

package dll_pkg;

  // default number of nodes in the pool
  localparam int unsigned POOL_NODES_DEF = 256;

  // fixed field widths of the request and result
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned NODE_W   = 8;
  localparam int unsigned COUNT_W  = 9;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_REM_NODE   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REM_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REM_BACK   = 3'd4;

  // one request
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NODE_W-1:0]   node_index;
  } dll_req_t;

  // one result
  typedef struct packed {
    logic [NODE_W-1:0]  head_node;
    logic [NODE_W-1:0]  tail_node;
    logic [COUNT_W-1:0] count;
    logic               empty_res;
    logic               error;
  } dll_res_t;

endpackage

`default_nettype wire

// ===== sv/dll_link_ram.sv =====
// one link table: synchronous memory with one write and one read port
// read data is registered; no dependencies
`default_nettype none

module dll_link_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 9
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/doubly_linked_list_manager.sv =====
// top level of the doubly linked list manager: control, list registers
// depends on dll_pkg and dll_link_ram (next and prev link tables)
`default_nettype none

// Usage
// A request (opcode, node_index on req_i) is taken at a rising edge with
// start_i high and busy_o low. Opcodes: push front, push back, remove a
// named node, remove front, remove tail.
// Each request gives exactly one result on res_o, marked by done_o for one
// cycle: head and tail node, count, empty flag and an error flag for a
// remove on an empty list. done_o and res_o are registered as the update
// state ends.
// In the request cycle the target node's next and prev entries are read from
// the two link memories (and a push writes its first link); in the update
// state the read links come back and the neighbour entries are written, with
// one write port per memory. busy_o is high in the update state, so a new
// request is taken only once the previous one has left that state.
// Writes finish before the next read is issued, so no forwarding is needed.
// Reset empties the list (head and tail null, count zero); link tables are not
// cleared; entries must only be read once written, the block does not enforce it.
// The receiver cannot stall: each result is marked by done_o for one cycle only.
module doubly_linked_list_manager #(
  parameter int unsigned POOL_NODES = dll_pkg::POOL_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire dll_pkg::dll_req_t req_i,
  output logic                   busy_o,
  output logic                   done_o,
  output dll_pkg::dll_res_t      res_o
);

  // link values hold a node or the null marker; index addresses the pool
  localparam int unsigned LW = $clog2(POOL_NODES + 1);
  localparam int unsigned IW = $clog2(POOL_NODES);
  localparam logic [LW-1:0] NULL_MARK = LW'(POOL_NODES);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  function automatic logic in_pool(input logic [LW-1:0] x);
    return x < NULL_MARK;
  endfunction

  state_e                          state_q;
  logic [dll_pkg::OPCODE_W-1:0]    op_q;
  logic [LW-1:0]                   node_q, node_d;
  logic                            ok_q, ok_d;
  logic [LW-1:0]                   head_q, head_d;
  logic [LW-1:0]                   tail_q, tail_d;
  logic [LW-1:0]                   count_q, count_d;
  logic                            done_q;
  dll_pkg::dll_res_t               res_q, res_d;
  logic                            err_d;

  logic                            accept;
  logic                            n_in_pool;
  logic [LW-1:0]                   n_ext;
  logic                            push_ok;
  logic [LW-1:0]                   rd_node;

  // memory ports
  logic                            next_we, prev_we;
  logic [IW-1:0]                   next_waddr, prev_waddr;
  logic [LW-1:0]                   next_wdata, prev_wdata;
  logic [IW-1:0]                   raddr;
  logic [LW-1:0]                   next_rdata, prev_rdata;

  // upd-cycle writes
  logic                            upd_next_we, upd_prev_we;
  logic [LW-1:0]                   upd_next_addr, upd_prev_addr;
  logic [LW-1:0]                   upd_next_data, upd_prev_data;

  // request decode
  assign accept    = start_i && (state_q == ST_IDLE);
  assign n_in_pool = 32'(req_i.node_index) < POOL_NODES;
  assign n_ext     = LW'(req_i.node_index);
  assign push_ok   = ((req_i.opcode == dll_pkg::OP_PUSH_FRONT) ||
                      (req_i.opcode == dll_pkg::OP_PUSH_BACK)) &&
                     n_in_pool && (count_q < NULL_MARK);

  // target node of the request and its validity
  always_comb begin
    node_d = n_in_pool ? n_ext : NULL_MARK;
    ok_d   = n_in_pool;
    unique case (req_i.opcode)
      dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_PUSH_BACK: ok_d = push_ok;
      dll_pkg::OP_REM_FRONT: begin
        node_d = head_q;
        ok_d   = 1'b1;
      end
      dll_pkg::OP_REM_BACK: begin
        node_d = tail_q;
        ok_d   = 1'b1;
      end
      default: ;
    endcase
  end

  assign rd_node = node_d;
  assign raddr   = in_pool(rd_node) ? rd_node[IW-1:0] : '0;

  // list update from the read links
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    err_d         = 1'b0;
    upd_next_we   = 1'b0;
    upd_prev_we   = 1'b0;
    upd_next_addr = node_q;
    upd_prev_addr = node_q;
    upd_next_data = NULL_MARK;
    upd_prev_data = NULL_MARK;
    unique case (op_q) inside
      dll_pkg::OP_PUSH_FRONT: begin
        if (ok_q) begin
          upd_next_we   = 1'b1;
          upd_next_addr = node_q;
          upd_next_data = head_q;
          upd_prev_we   = in_pool(head_q);
          upd_prev_addr = head_q;
          upd_prev_data = node_q;
          head_d        = node_q;
          if (count_q == '0) begin
            tail_d = node_q;
          end
          count_d = count_q + LW'(1);
        end
      end
      dll_pkg::OP_PUSH_BACK: begin
        if (ok_q) begin
          upd_prev_we   = 1'b1;
          upd_prev_addr = node_q;
          upd_prev_data = tail_q;
          upd_next_we   = in_pool(tail_q);
          upd_next_addr = tail_q;
          upd_next_data = node_q;
          tail_d        = node_q;
          if (count_q == '0) begin
            head_d = node_q;
          end
          count_d = count_q + LW'(1);
        end
      end
      dll_pkg::OP_REM_NODE, dll_pkg::OP_REM_FRONT, dll_pkg::OP_REM_BACK: begin
        if (count_q == '0) begin
          err_d = 1'b1;
        end else if (ok_q) begin
          if (head_q == node_q) begin
            // unlink the head
            if (count_q != LW'(1)) begin
              head_d        = in_pool(node_q) ? next_rdata : NULL_MARK;
              upd_prev_we   = in_pool(head_d);
              upd_prev_addr = head_d;
              upd_prev_data = NULL_MARK;
            end
          end else if (tail_q == node_q) begin
            // unlink the tail
            if (count_q != LW'(1)) begin
              tail_d        = in_pool(node_q) ? prev_rdata : NULL_MARK;
              upd_next_we   = in_pool(tail_d);
              upd_next_addr = tail_d;
              upd_next_data = NULL_MARK;
            end
          end else if (in_pool(node_q)) begin
            // join the neighbours of an inner node
            upd_next_we   = in_pool(prev_rdata);
            upd_next_addr = prev_rdata;
            upd_next_data = next_rdata;
            upd_prev_we   = in_pool(next_rdata);
            upd_prev_addr = next_rdata;
            upd_prev_data = prev_rdata;
          end
          count_d = count_q - LW'(1);
          if (count_d == '0) begin
            head_d = NULL_MARK;
            tail_d = NULL_MARK;
          end
        end
      end
      default: ;
    endcase
  end

  // memory write muxing: first link of a push at request, rest at update
  always_comb begin
    if (state_q == ST_UPDATE) begin
      next_we    = upd_next_we;
      next_waddr = upd_next_addr[IW-1:0];
      next_wdata = upd_next_data;
      prev_we    = upd_prev_we;
      prev_waddr = upd_prev_addr[IW-1:0];
      prev_wdata = upd_prev_data;
    end else begin
      next_we    = accept && push_ok && (req_i.opcode == dll_pkg::OP_PUSH_BACK);
      next_waddr = n_ext[IW-1:0];
      next_wdata = NULL_MARK;
      prev_we    = accept && push_ok && (req_i.opcode == dll_pkg::OP_PUSH_FRONT);
      prev_waddr = n_ext[IW-1:0];
      prev_wdata = NULL_MARK;
    end
  end

  // result fields after the update
  always_comb begin
    res_d.head_node = in_pool(head_d) ? dll_pkg::NODE_W'(head_d) : '0;
    res_d.tail_node = in_pool(tail_d) ? dll_pkg::NODE_W'(tail_d) : '0;
    res_d.count     = dll_pkg::COUNT_W'(count_d);
    res_d.empty_res = (count_d == '0);
    res_d.error     = err_d;
  end

  // link tables
  dll_link_ram #(
    .DEPTH (POOL_NODES),
    .WIDTH (LW)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (next_rdata)
  );

  dll_link_ram #(
    .DEPTH (POOL_NODES),
    .WIDTH (LW)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (prev_rdata)
  );

  // state, list registers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= '0;
      node_q  <= '0;
      ok_q    <= 1'b0;
      head_q  <= NULL_MARK;
      tail_q  <= NULL_MARK;
      count_q <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q    <= req_i.opcode;
            node_q  <= node_d;
            ok_q    <= ok_d;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          head_q  <= head_d;
          tail_q  <= tail_d;
          count_q <= count_d;
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q == ST_UPDATE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// ===== tb/tb_doubly_linked_list_manager.sv =====
// testbench of doubly_linked_list_manager: random and directed list requests
// checked against an in-bench list predictor; depends on dll_pkg and the dut
module tb_doubly_linked_list_manager;
  import dll_pkg::*;

  localparam int unsigned POOL        = POOL_NODES_DEF;
  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned ITEMS       = 1150;
  localparam int unsigned LIMIT_CYCLES = 300_000;

  // opcodes the block ignores
  localparam logic [OPCODE_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_HI = 3'd7;

  typedef logic [COUNT_W-1:0] link_t;
  localparam link_t NIL_LINK = link_t'(POOL);

  // one pending request with its idle chance and drain flag
  typedef struct packed {
    dll_req_t   req;
    logic [6:0] hold_pct;
    logic       drain;
  } pend_item_t;

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start_i = 1'b0;
  dll_req_t req_i   = '0;
  logic     busy_o;
  logic     done_o;
  dll_res_t res_o;

  // list predictor state
  link_t next_tbl [POOL];
  link_t prev_tbl [POOL];
  link_t head_ptr = NIL_LINK;
  link_t tail_ptr = NIL_LINK;
  link_t list_len = '0;

  // request stream and expected list summaries
  pend_item_t req_stream_q [$];
  dll_res_t   list_view_q [$];
  dll_res_t   want_res;

  // generator view of the list, used to keep sequences well formed
  int unsigned       gen_len = 0;
  logic [POOL-1:0]   ever_pushed = '0;
  logic [NODE_W-1:0] order_q [$];

  int unsigned total_n    = 0;
  int unsigned accepted_n = 0;
  int unsigned checked_n  = 0;
  int unsigned mismatch_n = 0;

  doubly_linked_list_manager dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic bit in_pool(input link_t n);
    return n < POOL;
  endfunction

  // link a node at the head or the tail
  function automatic void link_in(input link_t n, input bit at_front);
    if (list_len == 0) begin
      next_tbl[n[NODE_W-1:0]] = NIL_LINK;
      prev_tbl[n[NODE_W-1:0]] = NIL_LINK;
      head_ptr = n;
      tail_ptr = n;
    end else if (at_front) begin
      next_tbl[n[NODE_W-1:0]] = head_ptr;
      prev_tbl[n[NODE_W-1:0]] = NIL_LINK;
      if (in_pool(head_ptr)) prev_tbl[head_ptr[NODE_W-1:0]] = n;
      head_ptr = n;
    end else begin
      prev_tbl[n[NODE_W-1:0]] = tail_ptr;
      next_tbl[n[NODE_W-1:0]] = NIL_LINK;
      if (in_pool(tail_ptr)) next_tbl[tail_ptr[NODE_W-1:0]] = n;
      tail_ptr = n;
    end
    list_len++;
  endfunction

  // unlink a node; neighbours are joined through its own links
  function automatic void unlink(input link_t n);
    link_t up;
    link_t down;
    if (head_ptr == n) begin
      if (list_len == 1) begin
        head_ptr = NIL_LINK;
        tail_ptr = NIL_LINK;
      end else begin
        head_ptr = in_pool(n) ? next_tbl[n[NODE_W-1:0]] : NIL_LINK;
        if (in_pool(head_ptr)) prev_tbl[head_ptr[NODE_W-1:0]] = NIL_LINK;
      end
    end else if (tail_ptr == n) begin
      if (list_len == 1) begin
        head_ptr = NIL_LINK;
        tail_ptr = NIL_LINK;
      end else begin
        tail_ptr = in_pool(n) ? prev_tbl[n[NODE_W-1:0]] : NIL_LINK;
        if (in_pool(tail_ptr)) next_tbl[tail_ptr[NODE_W-1:0]] = NIL_LINK;
      end
    end else if (in_pool(n)) begin
      up   = prev_tbl[n[NODE_W-1:0]];
      down = next_tbl[n[NODE_W-1:0]];
      if (in_pool(up)) next_tbl[up[NODE_W-1:0]] = down;
      if (in_pool(down)) prev_tbl[down[NODE_W-1:0]] = up;
    end
    list_len--;
    if (list_len == 0) begin
      head_ptr = NIL_LINK;
      tail_ptr = NIL_LINK;
    end
  endfunction

  // apply one request and summarize the list afterwards
  function automatic dll_res_t apply_list_op(input dll_req_t rq);
    dll_res_t r;
    logic     err;
    err = 1'b0;
    case (rq.opcode)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_len < POOL) link_in({1'b0, rq.node_index}, rq.opcode == OP_PUSH_FRONT);
      end
      OP_REM_NODE, OP_REM_FRONT, OP_REM_BACK: begin
        if (list_len == 0) err = 1'b1;
        else if (rq.opcode == OP_REM_FRONT) unlink(head_ptr);
        else if (rq.opcode == OP_REM_BACK) unlink(tail_ptr);
        else unlink({1'b0, rq.node_index});
      end
      default: ;
    endcase
    r.head_node = in_pool(head_ptr) ? head_ptr[NODE_W-1:0] : '0;
    r.tail_node = in_pool(tail_ptr) ? tail_ptr[NODE_W-1:0] : '0;
    r.count     = list_len;
    r.empty_res = (list_len == 0);
    r.error     = err;
    return r;
  endfunction

  function automatic void flag_failure(input string msg);
    mismatch_n++;
    if (mismatch_n <= 10) $display("%s", msg);
  endfunction

  function automatic int find_listed(input logic [NODE_W-1:0] node);
    for (int k = 0; k < order_q.size(); k++) begin
      if (order_q[k] == node) return k;
    end
    return -1;
  endfunction

  // a node whose links were written: a listed one if any, else any pushed one, else a random one
  function automatic logic [NODE_W-1:0] linked_node_pick();
    int unsigned start;
    if (order_q.size() != 0) return order_q[$urandom_range(0, order_q.size() - 1)];
    start = $urandom_range(0, POOL - 1);
    for (int k = 0; k < POOL; k++) begin
      if (ever_pushed[(start + k) % POOL]) return NODE_W'((start + k) % POOL);
    end
    return NODE_W'(start);
  endfunction

  // queue one request and track the list length and order it leads to
  function automatic void add_item(input logic [OPCODE_W-1:0] op,
                                   input logic [NODE_W-1:0] node);
    pend_item_t it;
    int         idx;
    it.req.opcode     = op;
    it.req.node_index = node;
    it.hold_pct = (total_n < 300 || total_n >= 900) ? 7'd0 : (total_n < 600 ? 7'd78 : 7'd35);
    it.drain    = (total_n != 0) && (total_n % 300 == 0);
    req_stream_q.push_back(it);
    total_n++;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (gen_len < POOL) begin
          ever_pushed[node] = 1'b1;
          gen_len++;
          if (op == OP_PUSH_FRONT) order_q.push_front(node);
          else order_q.push_back(node);
        end
      end
      OP_REM_NODE, OP_REM_FRONT, OP_REM_BACK: begin
        if (gen_len != 0) begin
          gen_len--;
          if (order_q.size() != 0) begin
            if (op == OP_REM_FRONT) order_q.delete(0);
            else if (op == OP_REM_BACK) order_q.delete(order_q.size() - 1);
            else begin
              idx = find_listed(node);
              if (idx >= 0) order_q.delete(idx);
            end
          end
          if (gen_len == 0) order_q.delete();
        end
      end
      default: ;
    endcase
  endfunction

  // driver: predict on each accepted request, then present the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i   <= '0;
    end else begin
      if (start_i && !busy_o) begin
        list_view_q.push_back(apply_list_op(req_i));
        accepted_n++;
      end
      if (start_i && busy_o) begin
        // request not taken yet, hold it
      end else if (req_stream_q.size() != 0
                   && !(req_stream_q[0].drain && list_view_q.size() != 0)
                   && $urandom_range(0, 99) >= req_stream_q[0].hold_pct) begin
        req_i   <= req_stream_q[0].req;
        start_i <= 1'b1;
        req_stream_q.delete(0);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest expected summary
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (list_view_q.size() == 0) begin
        flag_failure($sformatf("result %0d arrived with no request pending", checked_n));
      end else begin
        want_res = list_view_q.pop_front();
        if (res_o.head_node !== want_res.head_node || res_o.tail_node !== want_res.tail_node
            || res_o.count !== want_res.count || res_o.empty_res !== want_res.empty_res
            || res_o.error !== want_res.error)
          flag_failure($sformatf(
            "result %0d: expected head %0d tail %0d count %0d empty %0b error %0b, got head %0d tail %0d count %0d empty %0b error %0b",
            checked_n, want_res.head_node, want_res.tail_node, want_res.count,
            want_res.empty_res, want_res.error, res_o.head_node, res_o.tail_node,
            res_o.count, res_o.empty_res, res_o.error));
      end
      checked_n++;
    end
  end

  initial begin : stimulus
    int unsigned       perm [POOL];
    int unsigned       j;
    int unsigned       swap;
    int                tries;
    logic [NODE_W-1:0] node;
    logic [OPCODE_W-1:0] op;

    // removes on an empty list, ignored opcodes
    add_item(OP_REM_FRONT, 8'd0);
    add_item(OP_REM_BACK, 8'd255);
    add_item(OP_REM_NODE, 8'd0);
    add_item(OP_RSVD_LO, 8'd255);
    add_item(OP_RSVD_HI, 8'd0);
    // build 1, 255, 0, 128 then remove middle, head and tail by name
    add_item(OP_PUSH_BACK, 8'd0);
    add_item(OP_PUSH_FRONT, 8'd255);
    add_item(OP_PUSH_BACK, 8'd128);
    add_item(OP_PUSH_FRONT, 8'd1);
    add_item(OP_REM_NODE, 8'd0);
    add_item(OP_REM_NODE, 8'd1);
    add_item(OP_REM_NODE, 8'd128);
    // end removals down to empty
    add_item(OP_PUSH_BACK, 8'd7);
    add_item(OP_REM_BACK, 8'd0);
    add_item(OP_REM_FRONT, 8'd255);
    add_item(OP_PUSH_FRONT, 8'd42);
    add_item(OP_REM_NODE, 8'd42);
    // push of a node already linked
    add_item(OP_PUSH_BACK, 8'd3);
    add_item(OP_PUSH_BACK, 8'd3);
    add_item(OP_REM_FRONT, 8'd0);
    add_item(OP_REM_FRONT, 8'd0);
    // remove of a node that is no longer linked, stale links
    add_item(OP_PUSH_FRONT, 8'd9);
    add_item(OP_REM_NODE, 8'd0);

    // fill the whole pool in random order, then push while full
    for (int k = 0; k < POOL; k++) perm[k] = k;
    for (int k = POOL - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      swap = perm[k];
      perm[k] = perm[j];
      perm[j] = swap;
    end
    for (int k = 0; k < POOL; k++)
      add_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, NODE_W'(perm[k]));
    add_item(OP_PUSH_BACK, NODE_W'($urandom_range(0, 255)));
    add_item(OP_PUSH_FRONT, NODE_W'($urandom_range(0, 255)));

    // random part: mostly well-formed list traffic, some noise
    while (total_n < ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        op   = OPCODE_W'($urandom_range(0, 7));
        node = NODE_W'($urandom_range(0, 255));
        if (op == OP_REM_NODE && gen_len != 0 && !ever_pushed[node]) node = linked_node_pick();
        add_item(op, node);
      end else if (gen_len == 0 || (gen_len < POOL && $urandom_range(0, 99)
                   < (gen_len < 8 ? 70 : (gen_len > 40 ? 20 : 45)))) begin
        tries = 0;
        do begin
          node = NODE_W'($urandom_range(0, 255));
          tries++;
        end while (find_listed(node) >= 0 && tries < 64);
        add_item($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, node);
      end else begin
        case ($urandom_range(0, 2))
          0:       add_item(OP_REM_FRONT, NODE_W'($urandom_range(0, 255)));
          1:       add_item(OP_REM_BACK, NODE_W'($urandom_range(0, 255)));
          default: add_item(OP_REM_NODE, linked_node_pick());
        endcase
      end
    end

    // reset once, then let the driver run the stream
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (accepted_n < total_n) @(posedge clk_i);
    while (list_view_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (list_view_q.size() != 0)
      flag_failure($sformatf("%0d results never arrived", list_view_q.size()));
    if (mismatch_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // run limit
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/dll_pkg.sv
sv/dll_link_ram.sv
sv/doubly_linked_list_manager.sv
tb/tb_doubly_linked_list_manager.sv
